[design/ac_ir_frame_pulse_encoder_core_defines.svh]
// Assertion helpers used by the encoder back end.
`ifndef AC_IR_FRAME_PULSE_ENCODER_CORE_DEFINES_SVH
`define AC_IR_FRAME_PULSE_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ACFPE_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("acfpe check failed");

// Next-cycle implication, checked out of reset.
`define ACFPE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("acfpe check failed");

`endif

[design/acfpe_pkg.sv]
package acfpe_pkg;

    typedef logic [47:0] frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  TEMP_MIN       = 8'd17;
    localparam logic [7:0]  TEMP_MAX       = 8'd30;
    localparam logic [7:0]  SENSOR_BYTE    = 8'hFF;
    localparam logic [2:0]  CMD_TYPE       = 3'b001;
    localparam logic [4:0]  CMD_HEADER     = 5'b10100;

    localparam logic [15:0] HDR_TICKS      = 16'd56;
    localparam logic [15:0] BIT_TICKS      = 16'd7;
    localparam logic [15:0] ONE_TICKS      = 16'd21;
    localparam logic [15:0] GAP_TICKS      = 16'd70;

    localparam logic [7:0]  TICK_RESET     = 8'd80;
    localparam logic [15:0] MSG_GAP_RESET  = 16'd30000;

    localparam logic [1:0]  REG_TICK       = 2'd0;
    localparam logic [1:0]  REG_MSG_GAP    = 2'd1;

    localparam logic [5:0]  RESULTS_PER_PHASE = 6'd25;
    localparam logic [5:0]  LAST_RESULT       = 6'd49;
    localparam logic [4:0]  FOOTER_SLOT       = 5'd24;

    localparam logic [2:0]  MODE_AUTO      = 3'd0;
    localparam logic [2:0]  MODE_COOL      = 3'd1;
    localparam logic [2:0]  MODE_DRY       = 3'd2;
    localparam logic [2:0]  MODE_FAN       = 3'd3;
    localparam logic [2:0]  MODE_HEAT      = 3'd4;

    localparam logic [2:0]  CODE_COOL      = 3'd0;
    localparam logic [2:0]  CODE_DRY       = 3'd1;
    localparam logic [2:0]  CODE_AUTO      = 3'd2;
    localparam logic [2:0]  CODE_HEAT      = 3'd3;
    localparam logic [2:0]  CODE_FAN       = 3'd4;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [2:0] mode_code(input logic [2:0] m);
        logic [2:0] c;
        case (m)
            MODE_COOL: c = CODE_COOL;
            MODE_DRY:  c = CODE_DRY;
            MODE_FAN:  c = CODE_FAN;
            MODE_HEAT: c = CODE_HEAT;
            default:   c = CODE_AUTO;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] fan_code(input logic [2:0] f);
        logic [1:0] c;
        if (f inside {[3'd0:3'd3]}) begin
            c = f[1:0];
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

endpackage

[design/acfpe_front.sv]
module acfpe_front
(
    input  logic [7:0]       temp_celsius,
    input  logic [2:0]       mode,
    input  logic [2:0]       fan_speed,
    input  logic             power_on,
    input  logic             push,
    input  acfpe_pkg::q_stat_t q_stat,
    output logic             wr_en,
    output acfpe_pkg::frame_t wr_frame
);

    logic [7:0] temp_clamped;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] rev_sum;
    logic [7:0] neg_sum;
    logic [7:0] byte0;

    always_comb
    begin
        if (temp_celsius < acfpe_pkg::TEMP_MIN) begin
            temp_clamped = acfpe_pkg::TEMP_MIN;
        end else if (temp_celsius > acfpe_pkg::TEMP_MAX) begin
            temp_clamped = acfpe_pkg::TEMP_MAX;
        end else begin
            temp_clamped = temp_celsius;
        end

        byte3 = temp_clamped - acfpe_pkg::TEMP_MIN;
        byte4 = {power_on, 2'b00, acfpe_pkg::fan_code(fan_speed),
                 acfpe_pkg::mode_code(mode)};
        byte5 = {acfpe_pkg::CMD_HEADER, acfpe_pkg::CMD_TYPE};

        // The checksum works on bit-reversed bytes, then reverses the result back.
        rev_sum = acfpe_pkg::bit_rev8(acfpe_pkg::SENSOR_BYTE)
                + acfpe_pkg::bit_rev8(acfpe_pkg::SENSOR_BYTE)
                + acfpe_pkg::bit_rev8(byte3)
                + acfpe_pkg::bit_rev8(byte4)
                + acfpe_pkg::bit_rev8(byte5);
        neg_sum = 8'd0 - rev_sum;
        byte0   = acfpe_pkg::bit_rev8(neg_sum);

        // Transmit order: byte 5 first, each byte MSB first.
        wr_frame = {byte5, byte4, byte3, acfpe_pkg::SENSOR_BYTE,
                    acfpe_pkg::SENSOR_BYTE, byte0};
        wr_en    = push && !q_stat.full;
    end

endmodule

[design/acfpe_queue.sv]
module acfpe_queue
#(
    parameter int DEPTH = acfpe_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  acfpe_pkg::frame_t  wr_frame,
    input  logic               rd_en,
    output acfpe_pkg::frame_t  rd_frame,
    output acfpe_pkg::q_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    acfpe_pkg::frame_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    always_comb
    begin
        do_wr = wr_en && (count_reg != CNT_FULL);
        do_rd = rd_en && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
        q_stat.full  = (count_reg == CNT_FULL);
        q_stat.empty = (count_reg == '0);
        rd_frame     = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/acfpe_back.sv]
`include "ac_ir_frame_pulse_encoder_core_defines.svh"

module acfpe_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  acfpe_pkg::q_stat_t q_stat,
    input  acfpe_pkg::frame_t  rd_frame,
    output logic               rd_en,
    input  logic               pop,
    output logic               empty,
    output logic [15:0]        mark_a_us,
    output logic [15:0]        space_a_us,
    output logic [15:0]        mark_b_us,
    output logic [15:0]        space_b_us,
    output logic               inverted_phase,
    output logic               last_pair
);

    logic [7:0]        tick_reg;
    logic [15:0]       gap_reg;
    logic              busy_reg, busy_next;
    logic [5:0]        idx_reg, idx_next;
    acfpe_pkg::frame_t frame_reg;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       mark_a_reg, space_a_reg, mark_b_reg, space_b_reg;
    logic              inv_reg, last_reg;

    logic              out_load;
    logic              phase;
    logic [5:0]        k_full;
    logic [4:0]        k;
    logic [63:0]       pat;
    logic [5:0]        ia;
    logic [5:0]        ib;
    logic              bit_a;
    logic              bit_b;
    logic [15:0]       t16;
    logic [15:0]       t_hdr, t_bit, t_one, t_gap;

    always_comb
    begin
        t16   = {8'd0, tick_reg};
        t_hdr = t16 * acfpe_pkg::HDR_TICKS;
        t_bit = t16 * acfpe_pkg::BIT_TICKS;
        t_one = t16 * acfpe_pkg::ONE_TICKS;
        t_gap = t16 * acfpe_pkg::GAP_TICKS;

        phase  = (idx_reg >= acfpe_pkg::RESULTS_PER_PHASE);
        k_full = phase ? (idx_reg - acfpe_pkg::RESULTS_PER_PHASE) : idx_reg;
        k      = k_full[4:0];

        // Zero padding keeps every index in range; the header and footer
        // slots never use the padded bits.
        pat   = {16'd0, (phase ? ~frame_reg : frame_reg)};
        ia    = 6'd48 - {k, 1'b0};
        ib    = 6'd47 - {k, 1'b0};
        bit_a = pat[ia];
        bit_b = pat[ib];

        out_load = busy_reg && (!out_valid_reg || pop);
        rd_en    = !busy_reg && !q_stat.empty;

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            if (idx_reg == acfpe_pkg::LAST_RESULT) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (rd_en) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end

        empty          = !out_valid_reg;
        mark_a_us      = mark_a_reg;
        space_a_us     = space_a_reg;
        mark_b_us      = mark_b_reg;
        space_b_us     = space_b_reg;
        inverted_phase = inv_reg;
        last_pair      = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            frame_reg <= rd_frame;
        end
        if (out_load) begin
            mark_a_reg  <= (k == '0) ? t_hdr : t_bit;
            space_a_reg <= (k == '0) ? t_hdr : (bit_a ? t_one : t_bit);
            mark_b_reg  <= t_bit;
            if (k == acfpe_pkg::FOOTER_SLOT) begin
                space_b_reg <= phase ? gap_reg : t_gap;
            end else begin
                space_b_reg <= bit_b ? t_one : t_bit;
            end
            inv_reg  <= phase;
            last_reg <= (idx_reg == acfpe_pkg::LAST_RESULT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tick_reg      <= acfpe_pkg::TICK_RESET;
            gap_reg       <= acfpe_pkg::MSG_GAP_RESET;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == acfpe_pkg::REG_TICK)) begin
                tick_reg <= cfg_data[7:0];
            end
            if (cfg_we && (cfg_index == acfpe_pkg::REG_MSG_GAP)) begin
                gap_reg <= cfg_data;
            end
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The final word of a command always belongs to the inverted phase.
    `ACFPE_ASSERT_NOW(a_last_inv, clk, rst_n, out_valid_reg && last_reg, inv_reg)
    // A new frame is taken only when the sequencer is free.
    `ACFPE_ASSERT_NOW(a_take_idle, clk, rst_n, rd_en, !busy_reg)
    `ACFPE_ASSERT_NOW(a_idx_range, clk, rst_n, busy_reg, idx_reg <= acfpe_pkg::LAST_RESULT)
    // Emitting the final word releases the sequencer.
    `ACFPE_ASSERT_NEXT(a_last_done, clk, rst_n,
        out_load && (idx_reg == acfpe_pkg::LAST_RESULT), !busy_reg)

endmodule

[design/ac_ir_frame_pulse_encoder_core.sv]
// Channel    Handshake            Payload
// command    push / full          temp_celsius, mode, fan_speed, power_on
// result     pop / empty          mark_a_us, space_a_us, mark_b_us, space_b_us,
//                                 inverted_phase, last_pair
// config     cfg_we               cfg_index, cfg_data
//
// Each command yields 50 result words, one per cycle while pop is held; the
// sequencer in the back end sets this and loads a frame from the queue only while
// it is idle, so it takes a new command only after the last word of the one before;
// a frame passes the frame queue and the frame register before its first word shows.
// Reset clears the frame queue, the sequencer and the output word; the registers
// return to tick 80 us and gap 30000 us. No clearing pass is needed.
// full rises only when the frame queue is full; a stalled pop holds the word.
module ac_ir_frame_pulse_encoder_core
#(
    parameter int QDEPTH = acfpe_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  temp_celsius,
    input  logic [2:0]  mode,
    input  logic [2:0]  fan_speed,
    input  logic        power_on,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] mark_a_us,
    output logic [15:0] space_a_us,
    output logic [15:0] mark_b_us,
    output logic [15:0] space_b_us,
    output logic        inverted_phase,
    output logic        last_pair,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    acfpe_pkg::q_stat_t q_stat;
    acfpe_pkg::frame_t  wr_frame;
    acfpe_pkg::frame_t  rd_frame;
    logic               wr_en;
    logic               rd_en;

    acfpe_front u_front
    (
        .temp_celsius (temp_celsius),
        .mode         (mode),
        .fan_speed    (fan_speed),
        .power_on     (power_on),
        .push         (push),
        .q_stat       (q_stat),
        .wr_en        (wr_en),
        .wr_frame     (wr_frame)
    );

    acfpe_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_frame (wr_frame),
        .rd_en    (rd_en),
        .rd_frame (rd_frame),
        .q_stat   (q_stat)
    );

    acfpe_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_stat         (q_stat),
        .rd_frame       (rd_frame),
        .rd_en          (rd_en),
        .pop            (pop),
        .empty          (empty),
        .mark_a_us      (mark_a_us),
        .space_a_us     (space_a_us),
        .mark_b_us      (mark_b_us),
        .space_b_us     (space_b_us),
        .inverted_phase (inverted_phase),
        .last_pair      (last_pair)
    );

    assign full = q_stat.full;

endmodule

[dv/ir_pair_checker.sv]
module ir_pair_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  temp_celsius,
    input  logic [2:0]  mode,
    input  logic [2:0]  fan_speed,
    input  logic        power_on,
    input  logic        pop,
    input  logic        empty,
    input  logic [15:0] mark_a_us,
    input  logic [15:0] space_a_us,
    input  logic [15:0] mark_b_us,
    input  logic [15:0] space_b_us,
    input  logic        inverted_phase,
    input  logic        last_pair,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pairs_owed,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0] mark_a;
        logic [15:0] space_a;
        logic [15:0] mark_b;
        logic [15:0] space_b;
        logic        inverted;
        logic        last;
    } pulse_pair_t;

    pulse_pair_t owed_pairs [$];
    logic [7:0]  tick_copy;
    logic [15:0] gap_copy;
    int          mismatches;

    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    // Builds the six-byte frame for one command and queues the fifty cell pairs it becomes.
    function automatic void predict_pairs(input logic [7:0] temp_in, input logic [2:0] mode_in,
                                          input logic [2:0] fan_in, input logic power_in);
        logic [7:0]  frame_bytes [6];
        logic [15:0] cell_mark [100];
        logic [15:0] cell_space [100];
        logic [7:0]  clamped;
        logic [7:0]  flip_sum;
        logic [7:0]  cur_byte;
        logic [2:0]  mcode;
        logic [1:0]  fcode;
        logic [15:0] hdr_us;
        logic [15:0] bit_us;
        logic [15:0] one_us;
        logic [15:0] gap_us;
        int          n;
        pulse_pair_t pp;

        if (temp_in < acfpe_pkg::TEMP_MIN)
        begin
            clamped = acfpe_pkg::TEMP_MIN;
        end
        else if (temp_in > acfpe_pkg::TEMP_MAX)
        begin
            clamped = acfpe_pkg::TEMP_MAX;
        end
        else
        begin
            clamped = temp_in;
        end

        case (mode_in)
            acfpe_pkg::MODE_COOL: mcode = acfpe_pkg::CODE_COOL;
            acfpe_pkg::MODE_DRY:  mcode = acfpe_pkg::CODE_DRY;
            acfpe_pkg::MODE_FAN:  mcode = acfpe_pkg::CODE_FAN;
            acfpe_pkg::MODE_HEAT: mcode = acfpe_pkg::CODE_HEAT;
            default:              mcode = acfpe_pkg::CODE_AUTO;
        endcase
        fcode = (fan_in <= 3'd3) ? fan_in[1:0] : 2'd0;

        frame_bytes[1] = acfpe_pkg::SENSOR_BYTE;
        frame_bytes[2] = acfpe_pkg::SENSOR_BYTE;
        frame_bytes[3] = clamped - acfpe_pkg::TEMP_MIN;
        frame_bytes[4] = {power_in, 2'b00, fcode, mcode};
        frame_bytes[5] = {acfpe_pkg::CMD_HEADER, acfpe_pkg::CMD_TYPE};
        flip_sum = 8'd0;
        for (int i = 1; i < 6; i++)
        begin
            flip_sum = flip_sum + flip_byte(frame_bytes[i]);
        end
        frame_bytes[0] = flip_byte(8'd0 - flip_sum);

        hdr_us = 16'(tick_copy) * acfpe_pkg::HDR_TICKS;
        bit_us = 16'(tick_copy) * acfpe_pkg::BIT_TICKS;
        one_us = 16'(tick_copy) * acfpe_pkg::ONE_TICKS;
        gap_us = 16'(tick_copy) * acfpe_pkg::GAP_TICKS;

        n = 0;
        for (int ph = 0; ph < 2; ph++)
        begin
            cell_mark[n]  = hdr_us;
            cell_space[n] = hdr_us;
            n++;
            for (int i = 5; i >= 0; i--)
            begin
                cur_byte = (ph != 0) ? ~frame_bytes[i] : frame_bytes[i];
                for (int b = 7; b >= 0; b--)
                begin
                    cell_mark[n]  = bit_us;
                    cell_space[n] = cur_byte[b] ? one_us : bit_us;
                    n++;
                end
            end
            cell_mark[n]  = bit_us;
            cell_space[n] = (ph != 0) ? gap_copy : gap_us;
            n++;
        end

        for (int k = 0; k < 50; k++)
        begin
            pp.mark_a   = cell_mark[2 * k];
            pp.space_a  = cell_space[2 * k];
            pp.mark_b   = cell_mark[2 * k + 1];
            pp.space_b  = cell_space[2 * k + 1];
            pp.inverted = (k >= int'(acfpe_pkg::RESULTS_PER_PHASE));
            pp.last     = (k == int'(acfpe_pkg::LAST_RESULT));
            owed_pairs.push_back(pp);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pulse_pair_t want;
        pulse_pair_t got;

        if (!rst_n)
        begin
            owed_pairs.delete();
            tick_copy      = acfpe_pkg::TICK_RESET;
            gap_copy       = acfpe_pkg::MSG_GAP_RESET;
            mismatches     = 0;
            pairs_owed     <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    acfpe_pkg::REG_TICK:    tick_copy = cfg_data[7:0];
                    acfpe_pkg::REG_MSG_GAP: gap_copy  = cfg_data;
                    default:                ;
                endcase
            end

            // The outgoing word always belongs to an earlier command, so it is
            // checked before this edge's command is predicted.
            if (pop && !empty)
            begin
                got = {mark_a_us, space_a_us, mark_b_us, space_b_us,
                       inverted_phase, last_pair};
                if (owed_pairs.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected word ma=%0d sa=%0d mb=%0d sb=%0d inv=%0b last=%0b",
                                 $realtime, got.mark_a, got.space_a, got.mark_b, got.space_b,
                                 got.inverted, got.last);
                    end
                    mismatches++;
                end
                else
                begin
                    want = owed_pairs.pop_front();
                    if (got.mark_a !== want.mark_a || got.space_a !== want.space_a ||
                        got.mark_b !== want.mark_b || got.space_b !== want.space_b ||
                        got.inverted !== want.inverted || got.last !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("%0t: expected ma=%0d sa=%0d mb=%0d sb=%0d inv=%0b last=%0b",
                                     $realtime, want.mark_a, want.space_a, want.mark_b,
                                     want.space_b, want.inverted, want.last);
                            $display("%0t: actual   ma=%0d sa=%0d mb=%0d sb=%0d inv=%0b last=%0b",
                                     $realtime, got.mark_a, got.space_a, got.mark_b,
                                     got.space_b, got.inverted, got.last);
                        end
                        mismatches++;
                    end
                end
            end

            if (push && !full)
            begin
                predict_pairs(temp_celsius, mode, fan_speed, power_on);
            end

            pairs_owed     <= owed_pairs.size();
            mismatch_count <= mismatches;
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD      = 8;
    localparam int         RESET_CYCLES    = 7;
    localparam int         CYCLE_LIMIT     = 1200000;
    localparam int         LONG_HOLD       = 400;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         ITEMS_PER_PHASE = 59;
    localparam int         TAIL_ITEMS      = 30;
    localparam int         SETTLE_CYCLES   = 64;
    // Indexes beyond the register list; writes to them must change nothing.
    localparam logic [1:0] REG_SPARE_A     = 2'd2;
    localparam logic [1:0] REG_SPARE_B     = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  temp_celsius;
    logic [2:0]  mode;
    logic [2:0]  fan_speed;
    logic        power_on;
    logic        pop;
    logic        empty;
    logic [15:0] mark_a_us;
    logic [15:0] space_a_us;
    logic [15:0] mark_b_us;
    logic [15:0] space_b_us;
    logic        inverted_phase;
    logic        last_pair;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          pairs_owed;
    int          mismatch_count;
    bit          long_hold_req = 1'b0;
    bit          tail_phase = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    ac_ir_frame_pulse_encoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .temp_celsius   (temp_celsius),
        .mode           (mode),
        .fan_speed      (fan_speed),
        .power_on       (power_on),
        .pop            (pop),
        .empty          (empty),
        .mark_a_us      (mark_a_us),
        .space_a_us     (space_a_us),
        .mark_b_us      (mark_b_us),
        .space_b_us     (space_b_us),
        .inverted_phase (inverted_phase),
        .last_pair      (last_pair),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ir_pair_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .temp_celsius   (temp_celsius),
        .mode           (mode),
        .fan_speed      (fan_speed),
        .power_on       (power_on),
        .pop            (pop),
        .empty          (empty),
        .mark_a_us      (mark_a_us),
        .space_a_us     (space_a_us),
        .mark_b_us      (mark_b_us),
        .space_b_us     (space_b_us),
        .inverted_phase (inverted_phase),
        .last_pair      (last_pair),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pairs_owed     (pairs_owed),
        .mismatch_count (mismatch_count)
    );

    // Offers one command and returns at the edge that takes it; push stays high
    // so back-to-back commands need no second assignment in one step.
    task automatic send_command(input logic [7:0] t, input logic [2:0] m,
                                input logic [2:0] f, input logic p);
        push         <= 1'b1;
        temp_celsius <= t;
        mode         <= m;
        fan_speed    <= f;
        power_on     <= p;
        do
        begin
            @(posedge clk);
        end
        while (full);
    endtask

    task automatic pause_source(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pairs_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_command();
        logic [7:0] t;

        // Most temperatures sit near the clamp window so both edges get hit often.
        if ($urandom_range(0, 4) != 0)
        begin
            t = 8'($urandom_range(10, 35));
        end
        else
        begin
            t = 8'($urandom_range(0, 255));
        end
        send_command(t, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
        if (!tail_phase && $urandom_range(0, 3) == 0)
        begin
            pause_source($urandom_range(1, 17));
        end
    endtask

    initial
    begin : command_source
        logic [7:0] edge_temps [16];

        edge_temps = '{8'd0, 8'd16, 8'd17, 8'd30, 8'd31, 8'd255, 8'd23, 8'd24,
                       8'd128, 8'd1, 8'd29, 8'd18, 8'd20, 8'd254, 8'd127, 8'd25};
        rst_n        = 1'b0;
        push         = 1'b0;
        temp_celsius = 8'd0;
        mode         = acfpe_pkg::MODE_AUTO;
        fan_speed    = 3'd0;
        power_on     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = acfpe_pkg::REG_TICK;
        cfg_data     = 16'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: clamp edges, every mode and fan code, both power states.
        for (int i = 0; i < 16; i++)
        begin
            send_command(edge_temps[i], 3'(i < 8 ? i : 15 - i), 3'(i < 8 ? 7 - i : i - 8),
                         1'(i < 8 ? i : i + 1));
            if ($urandom_range(0, 2) == 0)
            begin
                pause_source($urandom_range(1, 17));
            end
        end
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(acfpe_pkg::REG_TICK, 16'hFF01);
                    write_reg(acfpe_pkg::REG_MSG_GAP, 16'h0000);
                    write_reg(REG_SPARE_A, 16'hFFFF);
                end
                1:
                begin
                    write_reg(acfpe_pkg::REG_TICK, 16'h00FF);
                    write_reg(acfpe_pkg::REG_MSG_GAP, 16'hFFFF);
                    write_reg(REG_SPARE_B, 16'h5A5A);
                end
                2:
                begin
                    write_reg(acfpe_pkg::REG_TICK, 16'h0000);
                    write_reg(acfpe_pkg::REG_MSG_GAP, 16'($urandom_range(0, 65535)));
                end
                3:
                begin
                    write_reg(acfpe_pkg::REG_TICK, 16'(acfpe_pkg::TICK_RESET));
                    write_reg(acfpe_pkg::REG_MSG_GAP, acfpe_pkg::MSG_GAP_RESET);
                end
                default:
                begin
                    write_reg(acfpe_pkg::REG_TICK, 16'($urandom_range(1, 255)));
                    write_reg(acfpe_pkg::REG_MSG_GAP, 16'($urandom_range(0, 65535)));
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 3 && n == 5)
                begin
                    long_hold_req = 1'b1;
                end
                if (ph == RANDOM_PHASES - 1 && n == ITEMS_PER_PHASE - TAIL_ITEMS)
                begin
                    tail_phase = 1'b1;
                end
                send_random_command();
            end
            wait_drained();
        end

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin : result_sink
        int idle_left;
        int busy_left;

        idle_left = 0;
        busy_left = 0;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                idle_left = LONG_HOLD;
            end
            if (idle_left > 0)
            begin
                pop <= 1'b0;
                idle_left--;
            end
            else if (tail_phase || busy_left > 0)
            begin
                pop <= 1'b1;
                if (busy_left > 0)
                begin
                    busy_left--;
                end
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                idle_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                pop <= 1'b1;
                busy_left = $urandom_range(0, 60);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
